@@ rtl/core/shamp_pkg.sv @@
`default_nettype none

package shamp_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned TotalW = 61;
  localparam int unsigned LenW   = 64;
  // padded prefix is a multiple of 64 below 2^33, keep bits [32:6]
  localparam int unsigned PadW   = 27;

  localparam logic [ByteW-1:0] PadByte     = 8'h80;
  localparam logic [3:0]       ZeroWordRef = 4'd13;
  localparam logic [32:0]      PadExtra    = 33'd72;

  localparam logic [FuncW-1:0] FUNC_APPEND      = 2'd0;
  localparam logic [FuncW-1:0] FUNC_APPEND_LAST = 2'd1;
  localparam logic [FuncW-1:0] FUNC_FINISH      = 2'd2;
  localparam logic [FuncW-1:0] FUNC_NONE        = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/sha_message_padder_core.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | sink      | in_valid_i / in_stall_o    | func_i, data_byte_i
// out     | source    | out_valid_o / out_stall_i  | word_o, last_word_o
// cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_prefix_bytes_i
//
// Message bytes go through an input register and are taken at one per cycle
// while the input is not stalled. A finishing beat makes the sequencer emit 3
// to 18 words (0x80 word, 0 to 15 zero words, two length words), one per
// unstalled cycle via the single output register; the input register holds one
// further beat meanwhile. Reset clears the byte count, the held bytes and the
// prefix register. A stalled output holds its word; the input stalls only when
// its register is occupied by a beat that cannot move on.
`default_nettype none

module sha_message_padder_core
  import shamp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [FuncW-1:0]  func_i,
  input  wire logic [ByteW-1:0]  data_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WordW-1:0]       word_o,
  output logic                   last_word_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [WordW-1:0]  cfg_prefix_bytes_i
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_W80,
    ST_ZERO,
    ST_HI,
    ST_LO
  } state_e;

  state_e             state_q;
  logic               in_valid_q;
  logic [FuncW-1:0]   func_q;
  logic [ByteW-1:0]   byte_q;
  logic [23:0]        held_q;
  logic [TotalW-1:0]  total_q;
  logic [PadW-1:0]    pfx_pad_q;
  logic               out_valid_q;
  logic [WordW-1:0]   word_q;
  logic               last_q;
  logic [3:0]         zeros_q;
  logic [WordW-1:0]   w80_q;
  logic [LenW-1:0]    len_q;

  logic               out_free;
  logic               is_add;
  logic               is_fin;
  logic               byte_full;
  logic               take;
  logic [23:0]        held_nx;
  logic [5:0]         tot_lo;
  logic [WordW-1:0]   w80_nx;
  logic [3:0]         zeros_nx;
  logic [TotalW-1:0]  len_sum;
  logic [32:0]        pfx_sum;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_add    = (func_q == FUNC_APPEND) || (func_q == FUNC_APPEND_LAST);
  assign is_fin    = (func_q == FUNC_APPEND_LAST) || (func_q == FUNC_FINISH);
  assign byte_full = is_add && (total_q[1:0] == 2'd3);
  assign take      = in_valid_q && (state_q == ST_RUN) && (!byte_full || out_free);

  assign in_stall_o  = in_valid_q && !take;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign last_word_o = last_q;

  assign pfx_sum = {1'b0, cfg_prefix_bytes_i} + PadExtra;

  always_comb begin
    if (byte_full) begin
      held_nx = '0;
    end else if (is_add) begin
      held_nx = {held_q[15:0], byte_q};
    end else begin
      held_nx = held_q;
    end
    tot_lo = total_q[5:0] + {5'd0, is_add};
    case (tot_lo[1:0])
      2'd0:    w80_nx = {PadByte, 24'd0};
      2'd1:    w80_nx = {held_nx[7:0], PadByte, 16'd0};
      2'd2:    w80_nx = {held_nx[15:0], PadByte, 8'd0};
      default: w80_nx = {held_nx, PadByte};
    endcase
    zeros_nx = ZeroWordRef - tot_lo[5:2];
    len_sum  = total_q + {{(TotalW-PadW-6){1'b0}}, pfx_pad_q, 6'd0}
             + {{(TotalW-1){1'b0}}, is_add};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      in_valid_q  <= 1'b0;
      held_q      <= '0;
      total_q     <= '0;
      pfx_pad_q   <= '0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      last_q      <= 1'b0;
      zeros_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pfx_pad_q <= (cfg_prefix_bytes_i == '0) ? '0 : pfx_sum[32:6];
      end
      unique case (state_q)
        ST_RUN: begin
          if (out_free && !(take && byte_full)) begin
            out_valid_q <= 1'b0;
          end
          if (take) begin
            if (byte_full) begin
              out_valid_q <= 1'b1;
              word_q      <= {held_q, byte_q};
              last_q      <= 1'b0;
            end
            if (is_fin) begin
              held_q  <= '0;
              total_q <= '0;
              zeros_q <= zeros_nx;
              state_q <= ST_W80;
            end else if (is_add) begin
              held_q  <= held_nx;
              total_q <= total_q + {{(TotalW-1){1'b0}}, 1'b1};
            end
          end
        end
        ST_W80: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            word_q      <= w80_q;
            last_q      <= 1'b0;
            state_q     <= (zeros_q == '0) ? ST_HI : ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            word_q      <= '0;
            last_q      <= 1'b0;
            zeros_q     <= zeros_q - 4'd1;
            if (zeros_q == 4'd1) begin
              state_q <= ST_HI;
            end
          end
        end
        ST_HI: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            word_q      <= len_q[63:32];
            last_q      <= 1'b0;
            state_q     <= ST_LO;
          end
        end
        ST_LO: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            word_q      <= len_q[31:0];
            last_q      <= 1'b1;
            state_q     <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q <= func_i;
      byte_q <= data_byte_i;
    end
    if (take && is_fin) begin
      w80_q <= w80_nx;
      len_q <= {len_sum, 3'd0};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/shamp_checker.sv @@
`default_nettype none

module shamp_checker
  import shamp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [FuncW-1:0]  func_i,
  input wire logic [ByteW-1:0]  data_byte_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [WordW-1:0]  word_o,
  input wire logic              last_word_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic [WordW-1:0]  cfg_prefix_bytes_i
);

  logic out_beat;
  logic in_beat_none;

  assign out_beat     = out_valid_o && !out_stall_i;
  assign in_beat_none = in_valid_i && !in_stall_o && (func_i == FUNC_NONE)
                      && !cfg_valid_i && cfg_ready_o && (data_byte_i == data_byte_i)
                      && (cfg_prefix_bytes_i == cfg_prefix_bytes_i);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_o) && $stable(last_word_o))
    else $error("stalled output beat changed");

  // a final word is never followed at once by another final word
  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && last_word_o |=> !(out_valid_o && last_word_o))
    else $error("two final words back to back");

  // drop output valid while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // an unused code never starts a final word on its own
  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat_none && !out_valid_o |=> !(out_valid_o && last_word_o))
    else $error("unused code produced a final word");

endmodule

bind sha_message_padder_core shamp_checker u_shamp_checker (.*);

`default_nettype wire
